@@ rtl/core/gbte_pkg.sv @@
// Package: gap buffer editor constants, opcodes, states and control structs.
`timescale 1ns / 1ps
package gbte_pkg;
    localparam int CAPACITY = 4096;
    localparam int AW = $clog2(CAPACITY);
    localparam int PW = AW + 1;
    localparam logic [7:0] NEWLINE = 8'h0A;

    typedef enum logic [2:0] {
        OP_INSERT = 3'd0, OP_BKSP = 3'd1, OP_GOTO = 3'd2, OP_LEFT = 3'd3,
        OP_RIGHT = 3'd4, OP_UP = 3'd5, OP_DOWN = 3'd6, OP_READ = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0, ST_FULL = 2'd1, ST_NOP = 2'd2
    } t_status;

    // Scan reads go through the registered memory port: issue, then check.
    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_RD_ISSUE, S_RD_WAIT, S_SCAN_ISSUE, S_SCAN_WAIT,
        S_MOVE_ISSUE, S_MOVE_WAIT, S_RESULT
    } t_state;

    typedef enum logic [1:0] {
        SC_CUR_START, SC_PREV_START, SC_NEXT_NL, SC_NEXT_END
    } t_scan;

    // Commands from controller to datapath.
    typedef struct packed {
        logic         insert;   // write char at gap_begin, bump
        logic         bksp;
        logic         mem_rd;   // read address rd_addr
        logic [AW-1:0] rd_addr;
        logic         move_step; // complete one gap move step using read data
        logic         move_dir;  // 1 right
    } t_cmd;

    typedef struct packed {
        logic [PW-1:0] gap_begin;
        logic [PW-1:0] gap_finish;
        logic [PW-1:0] text_len;
        logic [7:0]    rd_data;
    } t_stat;
endpackage

@@ rtl/core/gbte_if.sv @@
// Valid/ready channel interfaces for commands and results.
`timescale 1ns / 1ps
interface gbte_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] opcode;
    logic [7:0] char_in;
    logic [12:0] target_pos;
    modport source (output valid, opcode, char_in, target_pos, input ready);
    modport sink (input valid, opcode, char_in, target_pos, output ready);
endinterface

interface gbte_res_if;
    logic        valid;
    logic        ready;
    logic [12:0] cursor_pos;
    logic [12:0] text_len;
    logic [7:0]  read_byte;
    logic [1:0]  status;
    modport source (output valid, cursor_pos, text_len, read_byte, status, input ready);
    modport sink (input valid, cursor_pos, text_len, read_byte, status, output ready);
endinterface

@@ rtl/core/gbte_datapath.sv @@
// Datapath: text store memory and gap pointers.
`timescale 1ns / 1ps
module gbte_datapath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  gbte_pkg::t_cmd  i_cmd,
    input  logic [7:0]      i_char,
    output gbte_pkg::t_stat o_stat
);
    logic [7:0] r_mem [gbte_pkg::CAPACITY];
    logic [7:0] r_rd_data;
    logic [gbte_pkg::PW-1:0] r_gb, r_gf, n_gb, n_gf;
    logic          wr_en;
    logic [gbte_pkg::AW-1:0] wr_addr;
    logic [7:0]    wr_data;

    always_comb begin
        n_gb = r_gb;
        n_gf = r_gf;
        wr_en = 1'b0;
        wr_addr = r_gb[gbte_pkg::AW-1:0];
        wr_data = i_char;
        if (i_cmd.insert) begin
            wr_en = 1'b1;
            n_gb = r_gb + 1'b1;
        end else if (i_cmd.bksp) begin
            n_gb = r_gb - 1'b1;
        end else if (i_cmd.move_step) begin
            wr_en = 1'b1;
            wr_data = r_rd_data;
            if (i_cmd.move_dir) begin
                // store[gb] = store[gf] (read earlier)
                wr_addr = r_gb[gbte_pkg::AW-1:0];
                n_gb = r_gb + 1'b1;
                n_gf = r_gf + 1'b1;
            end else begin
                wr_addr = gbte_pkg::AW'(r_gf - 1'b1);
                n_gb = r_gb - 1'b1;
                n_gf = r_gf - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gb <= '0;
            r_gf <= gbte_pkg::PW'(gbte_pkg::CAPACITY);
        end else begin
            r_gb <= n_gb;
            r_gf <= n_gf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
        if (i_cmd.mem_rd) r_rd_data <= r_mem[i_cmd.rd_addr];
    end

    assign o_stat.gap_begin  = r_gb;
    assign o_stat.gap_finish = r_gf;
    assign o_stat.text_len   = gbte_pkg::PW'(gbte_pkg::CAPACITY) - (r_gf - r_gb);
    assign o_stat.rd_data    = r_rd_data;

    a_gap_order: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_gb <= r_gf)
        else $error("gap begin past gap finish");
    a_gap_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gf <= gbte_pkg::PW'(gbte_pkg::CAPACITY)) else $error("gap finish past store");
    a_move_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.move_step |=> (r_gf - r_gb) == $past(r_gf - r_gb))
        else $error("gap move changed gap width");
endmodule

@@ rtl/core/gbte_ctrl.sv @@
// Controller: command sequencer for scans, gap moves and result.
`timescale 1ns / 1ps
module gbte_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    gbte_cmd_if.sink        cmd,
    gbte_res_if.source      res,
    input  gbte_pkg::t_stat i_stat,
    output gbte_pkg::t_cmd  o_cmd,
    output logic [7:0]      o_char
);
    localparam int PW = gbte_pkg::PW;
    localparam int AW = gbte_pkg::AW;

    gbte_pkg::t_state r_state, n_state;
    gbte_pkg::t_scan  r_scan, n_scan;
    logic [2:0]  r_op, n_op;
    logic [7:0]  r_ch, n_ch;
    logic [12:0] r_tgt, n_tgt;
    logic [PW-1:0] r_p, n_p;       // scan position
    logic [PW-1:0] r_mark, n_mark; // cur line start / next line start
    logic [PW-1:0] r_col, n_col;
    logic [PW-1:0] r_dest, n_dest;
    logic [1:0]  r_st, n_st;
    logic [7:0]  r_rb, n_rb;
    logic        r_ovalid, n_ovalid;
    logic [12:0] r_ocur, r_olen, n_ocur, n_olen;
    logic [7:0]  r_orb, n_orb;
    logic [1:0]  r_ost, n_ost;

    logic [PW-1:0] gb, gf, len, gapw, phys, scan_log, tclamp;
    logic [PW-1:0] prev_len, next_len, cmin;
    logic out_free;

    assign gb = i_stat.gap_begin;
    assign gf = i_stat.gap_finish;
    assign len = i_stat.text_len;
    assign gapw = gf - gb;
    assign out_free = !r_ovalid || res.ready;
    assign cmd.ready = (r_state == gbte_pkg::S_IDLE);
    assign o_char = r_ch;
    assign tclamp = (PW'(r_tgt) > len) ? len : PW'(r_tgt);
    // logical byte read in scans: p-1 for backward scans, p for forward
    assign scan_log = (r_scan == gbte_pkg::SC_CUR_START || r_scan == gbte_pkg::SC_PREV_START)
                      ? r_p - 1'b1 : r_p;
    assign phys = (scan_log < gb) ? scan_log : scan_log + gapw;
    assign prev_len = r_mark - 1'b1 - r_p;
    assign next_len = r_p - r_mark;

    always_comb begin
        n_state = r_state; n_scan = r_scan; n_op = r_op; n_ch = r_ch; n_tgt = r_tgt;
        n_p = r_p; n_mark = r_mark; n_col = r_col; n_dest = r_dest; n_st = r_st;
        n_rb = r_rb; n_ovalid = r_ovalid && !res.ready;
        n_ocur = r_ocur; n_olen = r_olen; n_orb = r_orb; n_ost = r_ost;
        o_cmd = '0;
        cmin = '0;
        case (r_state)
            gbte_pkg::S_IDLE: begin
                if (cmd.valid) begin
                    n_op = cmd.opcode; n_ch = cmd.char_in; n_tgt = cmd.target_pos;
                    n_state = gbte_pkg::S_DECODE;
                end
            end
            gbte_pkg::S_DECODE: begin
                n_st = gbte_pkg::ST_DONE;
                n_rb = '0;
                n_state = gbte_pkg::S_RESULT;
                case (gbte_pkg::t_op'(r_op))
                    gbte_pkg::OP_INSERT: begin
                        if (gb >= gf) n_st = gbte_pkg::ST_FULL;
                        else o_cmd.insert = 1'b1;
                    end
                    gbte_pkg::OP_BKSP: begin
                        if (gb != '0) o_cmd.bksp = 1'b1;
                        else n_st = gbte_pkg::ST_NOP;
                    end
                    gbte_pkg::OP_GOTO: begin
                        n_dest = tclamp;
                        n_state = gbte_pkg::S_MOVE_ISSUE;
                    end
                    gbte_pkg::OP_LEFT: begin
                        if (gb != '0) begin
                            n_dest = gb - 1'b1; n_state = gbte_pkg::S_MOVE_ISSUE;
                        end else n_st = gbte_pkg::ST_NOP;
                    end
                    gbte_pkg::OP_RIGHT: begin
                        if (gb < len) begin
                            n_dest = gb + 1'b1; n_state = gbte_pkg::S_MOVE_ISSUE;
                        end else n_st = gbte_pkg::ST_NOP;
                    end
                    gbte_pkg::OP_UP, gbte_pkg::OP_DOWN: begin
                        n_p = gb;
                        n_scan = gbte_pkg::SC_CUR_START;
                        n_state = gbte_pkg::S_SCAN_ISSUE;
                    end
                    gbte_pkg::OP_READ: begin
                        if (PW'(r_tgt) < len) n_state = gbte_pkg::S_RD_ISSUE;
                        else n_st = gbte_pkg::ST_NOP;
                    end
                    default: ;
                endcase
            end
            gbte_pkg::S_RD_ISSUE: begin
                o_cmd.mem_rd = 1'b1;
                o_cmd.rd_addr = (PW'(r_tgt) < gb) ? AW'(r_tgt) : AW'(PW'(r_tgt) + gapw);
                n_state = gbte_pkg::S_RD_WAIT;
            end
            gbte_pkg::S_RD_WAIT: begin
                n_rb = i_stat.rd_data;
                n_state = gbte_pkg::S_RESULT;
            end
            gbte_pkg::S_SCAN_ISSUE: begin
                // check termination without memory first
                if ((r_scan == gbte_pkg::SC_CUR_START || r_scan == gbte_pkg::SC_PREV_START)
                    && r_p == '0) begin
                    n_state = gbte_pkg::S_SCAN_WAIT;
                end else if ((r_scan == gbte_pkg::SC_NEXT_NL || r_scan == gbte_pkg::SC_NEXT_END)
                    && r_p >= len) begin
                    n_state = gbte_pkg::S_SCAN_WAIT;
                end else begin
                    o_cmd.mem_rd = 1'b1;
                    o_cmd.rd_addr = AW'(phys);
                    n_state = gbte_pkg::S_SCAN_WAIT;
                end
            end
            gbte_pkg::S_SCAN_WAIT: begin
                n_state = gbte_pkg::S_SCAN_ISSUE;
                case (r_scan)
                    gbte_pkg::SC_CUR_START, gbte_pkg::SC_PREV_START: begin
                        if (r_p != '0 && i_stat.rd_data != gbte_pkg::NEWLINE) begin
                            n_p = r_p - 1'b1;
                        end else if (r_scan == gbte_pkg::SC_CUR_START) begin
                            n_col = gb - r_p;
                            n_mark = r_p;
                            if (r_op == 3'(gbte_pkg::OP_UP)) begin
                                if (r_p == '0) begin
                                    n_st = gbte_pkg::ST_NOP; n_state = gbte_pkg::S_RESULT;
                                end else begin
                                    n_p = r_p - 1'b1;
                                    n_scan = gbte_pkg::SC_PREV_START;
                                end
                            end else begin
                                n_p = gb;
                                n_scan = gbte_pkg::SC_NEXT_NL;
                            end
                        end else begin
                            cmin = (r_col < prev_len) ? r_col : prev_len;
                            n_dest = r_p + cmin;
                            n_state = gbte_pkg::S_MOVE_ISSUE;
                        end
                    end
                    gbte_pkg::SC_NEXT_NL: begin
                        if (r_p >= len) begin
                            n_st = gbte_pkg::ST_NOP; n_state = gbte_pkg::S_RESULT;
                        end else if (i_stat.rd_data != gbte_pkg::NEWLINE) begin
                            n_p = r_p + 1'b1;
                        end else begin
                            n_p = r_p + 1'b1;
                            n_mark = r_p + 1'b1;
                            n_scan = gbte_pkg::SC_NEXT_END;
                        end
                    end
                    default: begin
                        if (r_p < len && i_stat.rd_data != gbte_pkg::NEWLINE) begin
                            n_p = r_p + 1'b1;
                        end else begin
                            cmin = (r_col < next_len) ? r_col : next_len;
                            n_dest = r_mark + cmin;
                            n_state = gbte_pkg::S_MOVE_ISSUE;
                        end
                    end
                endcase
            end
            gbte_pkg::S_MOVE_ISSUE: begin
                if (r_dest > gb && gf < PW'(gbte_pkg::CAPACITY)) begin
                    o_cmd.mem_rd = 1'b1;
                    o_cmd.rd_addr = AW'(gf);
                    n_state = gbte_pkg::S_MOVE_WAIT;
                end else if (r_dest < gb && gf != '0) begin
                    o_cmd.mem_rd = 1'b1;
                    o_cmd.rd_addr = AW'(gb - 1'b1);
                    n_state = gbte_pkg::S_MOVE_WAIT;
                end else begin
                    n_state = gbte_pkg::S_RESULT;
                end
            end
            gbte_pkg::S_MOVE_WAIT: begin
                o_cmd.move_step = 1'b1;
                o_cmd.move_dir = (r_dest > gb);
                n_state = gbte_pkg::S_MOVE_ISSUE;
            end
            gbte_pkg::S_RESULT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_ocur = gb[12:0];
                    n_olen = len[12:0];
                    n_orb = r_rb;
                    n_ost = r_st;
                    n_state = gbte_pkg::S_IDLE;
                end
            end
            default: n_state = gbte_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gbte_pkg::S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan <= n_scan; r_op <= n_op; r_ch <= n_ch; r_tgt <= n_tgt;
        r_p <= n_p; r_mark <= n_mark; r_col <= n_col; r_dest <= n_dest;
        r_st <= n_st; r_rb <= n_rb;
        r_ocur <= n_ocur; r_olen <= n_olen; r_orb <= n_orb; r_ost <= n_ost;
    end

    assign res.valid = r_ovalid;
    assign res.cursor_pos = r_ocur;
    assign res.text_len = r_olen;
    assign res.read_byte = r_orb;
    assign res.status = r_ost;

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.insert, o_cmd.bksp, o_cmd.move_step}))
        else $error("conflicting datapath commands");
    a_res_from_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state) == gbte_pkg::S_RESULT)
        else $error("result raised outside result state");
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.valid && cmd.ready) |=> r_state == gbte_pkg::S_DECODE)
        else $error("accepted request not decoded");
endmodule

@@ rtl/core/gap_buffer_text_editor_top.sv @@
// Top level: gap buffer text editor, controller plus datapath.
`timescale 1ns / 1ps
// One request at a time: insert and backspace go from decode straight to
// the result state, a read goes through a read issue and wait state first;
// moves shift the gap one byte per move issue/wait pair, and up/down also
// scan the text through the single store read port, one byte per scan
// issue/wait pair. The result sits in an output register; the next
// request is taken once the result is loaded.
module gap_buffer_text_editor_top (
    input logic         i_clk,
    input logic         i_rst_n,
    gbte_cmd_if.sink    cmd,
    gbte_res_if.source  res
);
    gbte_pkg::t_cmd  cmd_bus;
    gbte_pkg::t_stat stat_bus;
    logic [7:0]      ch;

    gbte_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .cmd(cmd), .res(res),
        .i_stat(stat_bus), .o_cmd(cmd_bus), .o_char(ch)
    );

    gbte_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd_bus), .i_char(ch),
        .o_stat(stat_bus)
    );
endmodule
